/* design/animated_sprite_slot_pool_unit_macros.svh */
// Assertion macros used by the sprite slot pool checker.
`ifndef ANIMATED_SPRITE_SLOT_POOL_UNIT_MACROS_SVH
`define ANIMATED_SPRITE_SLOT_POOL_UNIT_MACROS_SVH

// Same-cycle implication on clock, disabled while reset is high.
`define ASP_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sprite slot pool check failed");

// Next-cycle implication on clock, disabled while reset is high.
`define ASP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sprite slot pool check failed");

`endif

/* design/asp_pkg.sv */
// Types, codes and helpers of the sprite slot pool.
`default_nettype none
package asp_pkg;

   localparam int CsrIdxW       = 1;
   localparam int CsrDataW      = 8;
   localparam int VcountW       = 4;
   localparam int VehicleMax    = 15;
   localparam int ScreenXMax    = 167;
   localparam int ScreenYMax    = 175;
   localparam int ScreenYOffset = 16;
   localparam int TilePixels    = 8;
   localparam int TileShift     = $clog2(TilePixels);

   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_TICKS_PER_FRAME = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_FRAMES_PER_ANIM = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_IDLE  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_DRAW  = 2'd3
   } rec_kind_type;

   typedef struct packed {
      logic       busy;
      logic [7:0] frame;
      logic [7:0] tick;
      logic [5:0] sprite;
      logic [7:0] tile;
      logic [7:0] attr;
      logic       vehicle;
      logic [7:0] wx;
      logic [7:0] row;
   } slot_type;

   typedef struct packed {
      rec_kind_type kind;
      logic [2:0]   slot;
      logic         accepted;
      logic [5:0]   sprite_out;
      logic [7:0]   tile_out;
      logic [7:0]   attr_out;
      logic         move_valid;
      logic [7:0]   screen_x;
      logic [7:0]   screen_y;
   } rec_type;

   typedef struct packed {
      logic shift_en;
      logic load_en;
   } cell_ctrl_type;

   // True when this tick steps the last frame of a busy slot.
   function automatic logic slot_retires(slot_type s, logic [7:0] tpf, logic [7:0] fpa);
      logic [7:0] tick1;
      logic [7:0] frame1;
      tick1  = s.tick + 8'd1;
      frame1 = s.frame + 8'd1;
      return s.busy && (tick1 >= tpf) && (frame1 >= fpa);
   endfunction

endpackage
`default_nettype wire

/* design/asp_ifs.sv */
// Request and response channel interfaces of the sprite slot pool.
`default_nettype none
interface asp_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [5:0]  sprite_id;
   logic [7:0]  first_tile;
   logic [7:0]  attr_flags;
   logic        is_vehicle;
   logic [7:0]  world_x;
   logic [7:0]  world_tile_row;
   logic [7:0]  camera_x;
   logic [10:0] camera_y;

   modport source (output valid, op, sprite_id, first_tile, attr_flags, is_vehicle,
                   world_x, world_tile_row, camera_x, camera_y, input ready);
   modport sink (input valid, op, sprite_id, first_tile, attr_flags, is_vehicle,
                 world_x, world_tile_row, camera_x, camera_y, output ready);
endinterface

interface asp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] slot;
   logic       accepted;
   logic [5:0] sprite_out;
   logic [7:0] tile_out;
   logic [7:0] attr_out;
   logic       move_valid;
   logic [7:0] screen_x;
   logic [7:0] screen_y;
   logic       vehicles_done;
   logic       last;

   modport source (output valid, kind, slot, accepted, sprite_out, tile_out, attr_out,
                   move_valid, screen_x, screen_y, vehicles_done, last, input ready);
   modport sink (input valid, kind, slot, accepted, sprite_out, tile_out, attr_out,
                 move_valid, screen_x, screen_y, vehicles_done, last, output ready);
endinterface
`default_nettype wire

/* design/asp_cell.sv */
// One slot cell of the rotating slot ring.
`default_nettype none
module asp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  asp_pkg::cell_ctrl_type ctrl,
   input  asp_pkg::slot_type    shift_in,
   input  asp_pkg::slot_type    load_data,
   input  logic [7:0]           ticks_per_frame,
   input  logic [7:0]           frames_per_animation,
   output asp_pkg::slot_type    state,
   output logic                 retire_vehicle
);
   import asp_pkg::*;

   slot_type slot_ff;

   // Only the busy bit is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.busy <= 1'b0;
      end else if (ctrl.shift_en) begin
         slot_ff <= shift_in;
      end else if (ctrl.load_en) begin
         slot_ff <= load_data;
      end
   end

   assign state          = slot_ff;
   assign retire_vehicle = slot_ff.vehicle
                           && slot_retires(slot_ff, ticks_per_frame, frames_per_animation);
endmodule
`default_nettype wire

/* design/asp_update.sv */
// Tick update of the slot at the ring head and its output record.
`default_nettype none
module asp_update (
   input  asp_pkg::slot_type cur,
   input  logic [2:0]        slot_idx,
   input  logic [7:0]        ticks_per_frame,
   input  logic [7:0]        frames_per_animation,
   input  logic [7:0]        cam_x,
   input  logic [10:0]       cam_y,
   output asp_pkg::slot_type next,
   output asp_pkg::rec_type  rec
);
   import asp_pkg::*;

   logic [7:0]  tick1;
   logic [7:0]  frame1;
   logic [7:0]  frame_n;
   logic        step;
   logic        retire;
   logic [8:0]  dx;
   logic [11:0] ypix;
   logic [12:0] dy;
   logic        on_screen;

   always_comb begin
      tick1   = cur.tick + 8'd1;
      frame1  = cur.frame + 8'd1;
      step    = tick1 >= ticks_per_frame;
      retire  = slot_retires(cur, ticks_per_frame, frames_per_animation);
      frame_n = step ? frame1 : cur.frame;

      dx   = {1'b0, cur.wx} - {1'b0, cam_x};
      ypix = ({4'b0, cur.row} << TileShift) + 12'(ScreenYOffset);
      dy   = {1'b0, ypix} - {2'b0, cam_y};
      on_screen = !dx[8] && (dx[7:0] <= 8'(ScreenXMax))
                  && !dy[12] && (dy[11:0] <= 12'(ScreenYMax));

      next = cur;
      if (cur.busy) begin
         next.tick  = step ? 8'd0 : tick1;
         next.frame = frame_n;
         if (retire) begin
            next.busy = 1'b0;
         end
      end

      rec      = '0;
      rec.slot = slot_idx;
      if (!cur.busy) begin
         rec.kind = KIND_IDLE;
      end else if (retire) begin
         rec.kind       = KIND_CLEAR;
         rec.sprite_out = cur.sprite;
      end else begin
         rec.kind       = KIND_DRAW;
         rec.sprite_out = cur.sprite;
         rec.tile_out   = cur.tile + frame_n;
         rec.attr_out   = cur.attr;
         if (!cur.vehicle) begin
            rec.move_valid = 1'b1;
            if (on_screen) begin
               rec.screen_x = dx[7:0];
               rec.screen_y = dy[7:0];
            end
         end
      end
   end
endmodule
`default_nettype wire

/* design/animated_sprite_slot_pool_unit.sv */
// Spawn: acknowledgment in the output register in the cycle after acceptance; one spawn per
// cycle while the response is not stalled. Tick: a prepare state, then the slot ring rotates
// one cell per cycle through the head update unit while the response is not stalled, each
// rotation placing the head record in the output register. A new request is taken only once
// the block is back in idle after the last record; a stalled response halts the ring.
// Reset (synchronous): all slots free, vehicle count zero, both timing registers set to 4.
`default_nettype none
module animated_sprite_slot_pool_unit #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   asp_req_if.sink                       req_chan,
   asp_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [asp_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [asp_pkg::CsrDataW-1:0]  csr_wdata
);
   import asp_pkg::*;

   localparam int SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CountW = $clog2(NUM_SLOTS + 1);
   localparam int DecW   = (CountW > VcountW) ? CountW : VcountW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [SlotW-1:0]   pos_ff, pos_in;
   logic [7:0]         tpf_ff, fpa_ff;
   logic [7:0]         cam_x_ff, cam_x_in;
   logic [10:0]        cam_y_ff, cam_y_in;
   logic [VcountW-1:0] vcount_ff, vcount_in;
   logic               done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rec_type            rsp_rec_ff, rsp_rec_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_last_ff, rsp_last_in;

   slot_type           cell_state [NUM_SLOTS];
   slot_type           shift_src  [NUM_SLOTS];
   cell_ctrl_type      cell_ctrl  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] retire_vec;

   slot_type           load_data;
   slot_type           upd_next;
   rec_type            upd_rec;
   logic               out_free;
   logic               req_take;
   logic               spawn_take;
   logic               run_shift;
   logic               free_found;
   logic [SlotW-1:0]   free_idx;
   logic [SlotW+2:0]   free_wide;
   logic [SlotW+2:0]   pos_wide;
   logic [CountW-1:0]  ret_cnt;
   logic [DecW-1:0]    vc_ext;
   logic [DecW-1:0]    rc_ext;
   logic               pos_last;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_take   = req_chan.valid && req_chan.ready;
   assign spawn_take = req_take && (req_chan.op == OP_SPAWN) && free_found;
   assign run_shift  = (state_ff == ST_RUN) && out_free;
   assign pos_last   = pos_ff == SlotW'(NUM_SLOTS - 1);
   assign free_wide  = {3'b000, free_idx};
   assign pos_wide   = {3'b000, pos_ff};

   // Lowest-numbered free slot; the ring is aligned whenever the block is idle.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!cell_state[i].busy) begin
            free_found = 1'b1;
            free_idx   = SlotW'(i);
         end
      end
   end

   always_comb begin
      load_data         = '0;
      load_data.busy    = 1'b1;
      load_data.sprite  = req_chan.sprite_id;
      load_data.tile    = req_chan.first_tile;
      load_data.attr    = req_chan.attr_flags;
      load_data.vehicle = req_chan.is_vehicle;
      load_data.wx      = req_chan.world_x;
      load_data.row     = req_chan.world_tile_row;
   end

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      if (g == NUM_SLOTS - 1) begin : g_tail
         assign shift_src[g] = upd_next;
      end else begin : g_link
         assign shift_src[g] = cell_state[g + 1];
      end
      assign cell_ctrl[g].shift_en = run_shift;
      assign cell_ctrl[g].load_en  = spawn_take && (free_idx == SlotW'(g));

      asp_cell u_cell (
         .clock               (clock),
         .reset               (reset),
         .ctrl                (cell_ctrl[g]),
         .shift_in            (shift_src[g]),
         .load_data           (load_data),
         .ticks_per_frame     (tpf_ff),
         .frames_per_animation(fpa_ff),
         .state               (cell_state[g]),
         .retire_vehicle      (retire_vec[g])
      );
   end

   asp_update u_update (
      .cur                 (cell_state[0]),
      .slot_idx            (pos_wide[2:0]),
      .ticks_per_frame     (tpf_ff),
      .frames_per_animation(fpa_ff),
      .cam_x               (cam_x_ff),
      .cam_y               (cam_y_ff),
      .next                (upd_next),
      .rec                 (upd_rec)
   );

   assign ret_cnt = CountW'($countones(retire_vec));
   assign vc_ext  = DecW'(vcount_ff);
   assign rc_ext  = DecW'(ret_cnt);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cam_x_in     = cam_x_ff;
      cam_y_in     = cam_y_ff;
      vcount_in    = vcount_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rec_in   = rsp_rec_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.op == OP_SPAWN) begin
                  if (spawn_take && req_chan.is_vehicle
                      && (vcount_ff != VcountW'(VehicleMax))) begin
                     vcount_in = vcount_ff + VcountW'(1);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_rec_in   = '0;
                  rsp_rec_in.kind     = KIND_ACK;
                  rsp_rec_in.accepted = free_found;
                  rsp_rec_in.slot     = free_found ? free_wide[2:0] : 3'b000;
                  rsp_done_in  = vcount_in == '0;
                  rsp_last_in  = 1'b1;
               end else begin
                  cam_x_in = req_chan.camera_x;
                  cam_y_in = req_chan.camera_y;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            // Count comes out final before the first record, since every record carries its done flag.
            vcount_in = (vc_ext >= rc_ext) ? VcountW'(vc_ext - rc_ext) : '0;
            done_in   = vcount_in == '0;
            pos_in    = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = upd_rec;
               rsp_done_in  = done_ff;
               rsp_last_in  = pos_last;
               pos_in       = pos_ff + SlotW'(1);
               if (pos_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vcount_ff    <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         tpf_ff       <= 8'd4;
         fpa_ff       <= 8'd4;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vcount_ff    <= vcount_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TICKS_PER_FRAME: tpf_ff <= csr_wdata;
               CSR_FRAMES_PER_ANIM: fpa_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cam_x_ff    <= cam_x_in;
      cam_y_ff    <= cam_y_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_done_ff <= rsp_done_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_rec_ff.kind;
   assign rsp_chan.slot          = rsp_rec_ff.slot;
   assign rsp_chan.accepted      = rsp_rec_ff.accepted;
   assign rsp_chan.sprite_out    = rsp_rec_ff.sprite_out;
   assign rsp_chan.tile_out      = rsp_rec_ff.tile_out;
   assign rsp_chan.attr_out      = rsp_rec_ff.attr_out;
   assign rsp_chan.move_valid    = rsp_rec_ff.move_valid;
   assign rsp_chan.screen_x      = rsp_rec_ff.screen_x;
   assign rsp_chan.screen_y      = rsp_rec_ff.screen_y;
   assign rsp_chan.vehicles_done = rsp_done_ff;
   assign rsp_chan.last          = rsp_last_ff;
endmodule
`default_nettype wire

/* design/asp_checker.sv */
// Port-level checker of the sprite slot pool and its bind.
`default_nettype none
`include "animated_sprite_slot_pool_unit_macros.svh"
module asp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [2:0] rsp_slot,
   input logic       rsp_accepted,
   input logic       rsp_move_valid,
   input logic       rsp_last
);
   import asp_pkg::*;

   logic spawn_take;
   logic tick_take;
   logic rsp_stall;
   logic drop_ack;

   assign spawn_take = req_valid && req_ready && (req_op == OP_SPAWN);
   assign tick_take  = req_valid && req_ready && (req_op == OP_TICK);
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign drop_ack   = rsp_valid && (rsp_kind == KIND_ACK) && !rsp_accepted;

   `ASP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_slot))
   `ASP_ASSERT_NEXT(a_spawn_ack, spawn_take, rsp_valid && rsp_kind == KIND_ACK && rsp_last)
   `ASP_ASSERT_NEXT(a_tick_busy, tick_take, !req_ready)
   `ASP_ASSERT_NOW(a_move_draw, rsp_valid && rsp_move_valid, rsp_kind == KIND_DRAW)
   `ASP_ASSERT_NOW(a_drop_slot, drop_ack, rsp_slot == 3'b000)
endmodule

bind animated_sprite_slot_pool_unit asp_checker u_asp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_op        (req_chan.op),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_slot      (rsp_chan.slot),
   .rsp_accepted  (rsp_chan.accepted),
   .rsp_move_valid(rsp_chan.move_valid),
   .rsp_last      (rsp_chan.last)
);
`default_nettype wire
